// ===== sv/bpir_pkg.sv =====
// Shared types, constants and helpers for the box pair impulse resolver.
`default_nettype none
package bpir_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned MASS_W    = 16;
    localparam int unsigned QTY_W     = COORD_W + 1;          // overlap or closing speed
    localparam int unsigned SUM_W     = MASS_W + 1;           // first_mass + second_mass
    localparam int unsigned PROD_W    = QTY_W + MASS_W;       // quantity times mass
    localparam int unsigned DIV_STEPS = QTY_W;                // quotient never exceeds quantity
    localparam int unsigned LANES     = 4;

    // Lane order inside the divider bank.
    localparam int unsigned LANE_D1 = 0;
    localparam int unsigned LANE_D2 = 1;
    localparam int unsigned LANE_W1 = 2;
    localparam int unsigned LANE_W2 = 3;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [QTY_W-1:0] low;
    } div_lane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] v1;
        logic signed [COORD_W-1:0] v2;
        logic [MASS_W-1:0]         m1;
        logic [MASS_W-1:0]         m2;
        logic [SUM_W-1:0]          msum;
        logic [QTY_W-1:0]          ov;
        logic [QTY_W-1:0]          rel;
        logic                      first_low;
        logic                      closing;
        logic                      done;
    } ctx_t;

    // One restoring-division step: bring in the next dividend bit, subtract if it fits.
    function automatic div_lane_t div_step(input div_lane_t cur, input logic [SUM_W-1:0] dvs);
        logic [SUM_W:0] trial;
        div_lane_t      nxt;
        trial = {cur.rem, cur.low[QTY_W-1]};
        if (trial >= {1'b0, dvs}) begin
            nxt.rem = SUM_W'(trial - {1'b0, dvs});
            nxt.low = {cur.low[QTY_W-2:0], 1'b1};
        end else begin
            nxt.rem = trial[SUM_W-1:0];
            nxt.low = {cur.low[QTY_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Clamp a 34-bit signed value into the 32-bit signed range.
    function automatic logic [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
        logic [COORD_W-1:0] res;
        if (v > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/box_pair_impulse_resolver_unit.sv =====
// Top level of the box pair impulse resolver: pipelined overlap test, split and impulse.
//
// Usage: present one box pair per request on the s_ channel (valid/ready). The caller
// orders each box's edges as along (axis being resolved) and across (other axis), so
// the same unit serves both passes. Every request yields exactly one result on the
// m_ channel: position shifts, new speeds and a resolved flag.
// Pipeline: 37 register stages (input register, overlap stage, multiply stage, 33 divider
// steps, output stage). Throughput: one request per cycle while no result waits on a
// stalled receiver. The mass-weighted shares need four divisions of a 49-bit product by
// the 17-bit mass sum; a bank of four restoring dividers, one quotient bit per stage,
// sets the depth and lets a new pair enter every cycle.
// Reset (aresetn low, synchronous) drops every in-flight request and clears m_valid.
// When the receiver stalls with a result waiting, the whole pipeline holds, empty
// stages included, and s_ready falls; no request is dropped or repeated.
`default_nettype none
module box_pair_impulse_resolver_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_first_along_min,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_first_along_max,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_first_across_min,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_first_across_max,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_second_along_min,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_second_along_max,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_second_across_min,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_second_across_max,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_first_speed,
    input  wire logic signed [bpir_pkg::COORD_W-1:0] s_second_speed,
    input  wire logic [bpir_pkg::MASS_W-1:0]         s_first_mass,
    input  wire logic [bpir_pkg::MASS_W-1:0]         s_second_mass,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [bpir_pkg::COORD_W-1:0]    m_first_shift,
    output logic signed [bpir_pkg::COORD_W-1:0]    m_second_shift,
    output logic signed [bpir_pkg::COORD_W-1:0]    m_first_speed_out,
    output logic signed [bpir_pkg::COORD_W-1:0]    m_second_speed_out,
    output logic                                   m_resolved
);
    import bpir_pkg::*;

    // Advance the whole pipe unless a finished result is waiting on a stalled receiver.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage A: input register ----------------
    logic                      a_vld_reg;
    logic signed [COORD_W-1:0] a_a1lo_reg, a_a1hi_reg, a_c1lo_reg, a_c1hi_reg;
    logic signed [COORD_W-1:0] a_a2lo_reg, a_a2hi_reg, a_c2lo_reg, a_c2hi_reg;
    logic signed [COORD_W-1:0] a_v1_reg, a_v2_reg;
    logic [MASS_W-1:0]         a_m1_reg, a_m2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_valid;
        end
        if (adv) begin
            a_a1lo_reg <= s_first_along_min;
            a_a1hi_reg <= s_first_along_max;
            a_c1lo_reg <= s_first_across_min;
            a_c1hi_reg <= s_first_across_max;
            a_a2lo_reg <= s_second_along_min;
            a_a2hi_reg <= s_second_along_max;
            a_c2lo_reg <= s_second_across_min;
            a_c2hi_reg <= s_second_across_max;
            a_v1_reg   <= s_first_speed;
            a_v2_reg   <= s_second_speed;
            a_m1_reg   <= s_first_mass;
            a_m2_reg   <= s_second_mass;
        end
    end

    // ---------------- stage B: overlaps, ordering, closing speed ----------------
    logic signed [COORD_W+1:0] ov_along, ov_across;
    logic signed [COORD_W:0]   sum1, sum2, rel_s;
    logic                      first_low;
    ctx_t                      b_ctx_next, b_ctx_reg;
    logic                      b_vld_reg;

    always_comb begin
        ov_along  = (COORD_W+2)'(a_a1hi_reg < a_a2hi_reg ? a_a1hi_reg : a_a2hi_reg)
                  - (COORD_W+2)'(a_a1lo_reg > a_a2lo_reg ? a_a1lo_reg : a_a2lo_reg);
        ov_across = (COORD_W+2)'(a_c1hi_reg < a_c2hi_reg ? a_c1hi_reg : a_c2hi_reg)
                  - (COORD_W+2)'(a_c1lo_reg > a_c2lo_reg ? a_c1lo_reg : a_c2lo_reg);
        sum1      = (COORD_W+1)'(a_a1lo_reg) + (COORD_W+1)'(a_a1hi_reg);
        sum2      = (COORD_W+1)'(a_a2lo_reg) + (COORD_W+1)'(a_a2hi_reg);
        first_low = sum1 < sum2;
        rel_s     = first_low ? (COORD_W+1)'(a_v1_reg) - (COORD_W+1)'(a_v2_reg)
                              : (COORD_W+1)'(a_v2_reg) - (COORD_W+1)'(a_v1_reg);

        b_ctx_next.v1        = a_v1_reg;
        b_ctx_next.v2        = a_v2_reg;
        b_ctx_next.m1        = a_m1_reg;
        b_ctx_next.m2        = a_m2_reg;
        b_ctx_next.msum      = SUM_W'(a_m1_reg) + SUM_W'(a_m2_reg);
        b_ctx_next.ov        = ov_along[QTY_W-1:0];
        b_ctx_next.first_low = first_low;
        b_ctx_next.closing   = rel_s > 0;
        // A resting or separating pair carries no impulse: zero the quantity.
        b_ctx_next.rel       = (rel_s > 0) ? rel_s[QTY_W-1:0] : '0;
        b_ctx_next.done      = (a_m1_reg != '0 || a_m2_reg != '0)
                             && ov_along > 0 && ov_across > 0 && ov_along < ov_across;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
        if (adv) begin
            b_ctx_reg <= b_ctx_next;
        end
    end

    // ---------------- stage C: products, loaded into the divider bank ----------------
    ctx_t      ctx_reg [0:DIV_STEPS];
    logic      vld_reg [0:DIV_STEPS];
    div_lane_t dv_reg  [0:DIV_STEPS][0:LANES-1];
    logic [PROD_W-1:0] prod [0:LANES-1];
    div_lane_t         load_next [0:LANES-1];

    always_comb begin
        prod[LANE_D1] = PROD_W'(b_ctx_reg.ov)  * PROD_W'(b_ctx_reg.m2);
        prod[LANE_D2] = PROD_W'(b_ctx_reg.ov)  * PROD_W'(b_ctx_reg.m1);
        prod[LANE_W1] = PROD_W'(b_ctx_reg.rel) * PROD_W'(b_ctx_reg.m2);
        prod[LANE_W2] = PROD_W'(b_ctx_reg.rel) * PROD_W'(b_ctx_reg.m1);
        for (int i = 0; i < LANES; i++) begin
            // Quotient fits in QTY_W bits, so the high part starts below the divisor.
            load_next[i].rem = {1'b0, prod[i][PROD_W-1:QTY_W]};
            load_next[i].low = prod[i][QTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= b_vld_reg;
        end
        if (adv) begin
            ctx_reg[0] <= b_ctx_reg;
            for (int i = 0; i < LANES; i++) begin
                dv_reg[0][i] <= load_next[i];
            end
        end
    end

    // ---------------- divider stages: one quotient bit per lane per stage ----------------
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        div_lane_t step_next [0:LANES-1];

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                step_next[i] = div_step(dv_reg[k-1][i], ctx_reg[k-1].msum);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (adv) begin
                ctx_reg[k] <= ctx_reg[k-1];
                for (int i = 0; i < LANES; i++) begin
                    dv_reg[k][i] <= step_next[i];
                end
            end
        end
    end

    // ---------------- output stage: pick shares, apply, saturate ----------------
    ctx_t                      fc;
    logic [QTY_W-1:0]          d1, d2, w1, w2;
    logic signed [COORD_W+1:0] s1_w, s2_w, nv1_w, nv2_w;
    logic                      m_valid_reg, m_valid_next;
    logic [COORD_W-1:0]        shift1_next, shift2_next, speed1_next, speed2_next;
    logic [COORD_W-1:0]        shift1_reg, shift2_reg, speed1_reg, speed2_reg;
    logic                      resolved_reg;

    always_comb begin
        fc = ctx_reg[DIV_STEPS];
        // A kinematic body takes nothing; facing a kinematic body, take it all.
        d1 = (fc.m1 == '0) ? '0 : (fc.m2 == '0) ? fc.ov  : dv_reg[DIV_STEPS][LANE_D1].low;
        d2 = (fc.m2 == '0) ? '0 : (fc.m1 == '0) ? fc.ov  : dv_reg[DIV_STEPS][LANE_D2].low;
        w1 = (fc.m1 == '0) ? '0 : (fc.m2 == '0) ? fc.rel : dv_reg[DIV_STEPS][LANE_W1].low;
        w2 = (fc.m2 == '0) ? '0 : (fc.m1 == '0) ? fc.rel : dv_reg[DIV_STEPS][LANE_W2].low;
        if (!fc.closing) begin
            w1 = '0;
            w2 = '0;
        end
        if (fc.first_low) begin
            s1_w  = -$signed((COORD_W+2)'(d1));
            s2_w  =  $signed((COORD_W+2)'(d2));
            nv1_w = (COORD_W+2)'(fc.v1) - $signed((COORD_W+2)'(w1));
            nv2_w = (COORD_W+2)'(fc.v2) + $signed((COORD_W+2)'(w2));
        end else begin
            s1_w  =  $signed((COORD_W+2)'(d1));
            s2_w  = -$signed((COORD_W+2)'(d2));
            nv1_w = (COORD_W+2)'(fc.v1) + $signed((COORD_W+2)'(w1));
            nv2_w = (COORD_W+2)'(fc.v2) - $signed((COORD_W+2)'(w2));
        end
        if (fc.done) begin
            shift1_next = sat32(s1_w);
            shift2_next = sat32(s2_w);
            speed1_next = sat32(nv1_w);
            speed2_next = sat32(nv2_w);
        end else begin
            // Unresolved pair: pass speeds through, no shift.
            shift1_next = '0;
            shift2_next = '0;
            speed1_next = fc.v1;
            speed2_next = fc.v2;
        end
        m_valid_next = vld_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
        if (adv) begin
            shift1_reg   <= shift1_next;
            shift2_reg   <= shift2_next;
            speed1_reg   <= speed1_next;
            speed2_reg   <= speed2_next;
            resolved_reg <= fc.done;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_first_shift      = shift1_reg;
    assign m_second_shift     = shift2_reg;
    assign m_first_speed_out  = speed1_reg;
    assign m_second_speed_out = speed2_reg;
    assign m_resolved         = resolved_reg;

    // ---------------- assertions ----------------
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_unresolved_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_resolved) |-> (m_first_shift == '0 && m_second_shift == '0))
        else $error("unresolved pair carries a shift");

    a_shifts_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_resolved) |->
            !((m_first_shift > 0 && m_second_shift > 0) ||
              (m_first_shift < 0 && m_second_shift < 0)))
        else $error("bodies pushed the same way");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(vld_reg[DIV_STEPS])))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
